/* src/three_queue_shortest_dispatch_top_defines.svh */
// assertion macros for the three-queue shortest dispatch block
// used by the controller; expects signals clk and rst_n in scope
`ifndef THREE_QUEUE_SHORTEST_DISPATCH_TOP_DEFINES_SVH
`define THREE_QUEUE_SHORTEST_DISPATCH_TOP_DEFINES_SVH

// checked only while out of reset
`define TQSD_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define TQSD_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/tqsd_pkg.sv */
// shared widths, codes and types for the three-queue shortest dispatch block
// no dependencies
`timescale 1ns / 1ps

package tqsd_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int QUEUE_COUNT = 3;
  localparam int SLOT_COUNT  = QUEUE_COUNT * QUEUE_DEPTH;

  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int OCC_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W  = $clog2(SLOT_COUNT);
  localparam int QSEL_W  = 2;
  localparam int LIMIT_W = 5;
  localparam int CMP_W   = (OCC_W > LIMIT_W) ? OCC_W : LIMIT_W;

  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int ID_W     = 32;
  localparam int COUNT_W  = 16;
  localparam int CENTS_W  = 32;
  localparam int TOTAL_W  = 36;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = CFG_ADDR_W - 2;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LIMIT = '0;
  localparam logic [LIMIT_W-1:0]   LIMIT_RESET   = 5'd10;

  localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_AUTO  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_TOTAL = 2'd3;

  localparam logic [STATUS_W-1:0] STS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STS_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STS_EMPTY   = 2'd2;
  localparam logic [STATUS_W-1:0] STS_INVALID = 2'd3;

  localparam logic [QSEL_W-1:0] Q_NONE = 2'd0;

  typedef struct packed {
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [CENTS_W-1:0] wr_data;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
  } ram_req_t;

endpackage

/* src/three_queue_shortest_dispatch_top.sv */
// channel    | handshake                  | payload
// cfg (apb)  | psel penable pwrite pready | paddr pwdata prdata
// in         | in_valid / in_stall        | command, queue_select, count, cents
// out        | out_valid / out_stall      | status, queue_used, client_id, total
//
// push and pop go from acceptance to result through the latch, decode and result states.
// total adds a walk between decode and result: the store's single read port feeds
// one value a cycle into the accumulator, the last value lands in the cycle after
// its read, and the walk closes once no read is pending.
// one item at a time; in_stall is high from acceptance until its result is
// moved to the output register, which holds it while out_stall is high.
// synchronous reset empties all queues and zeroes the id counter; no clearing pass.
`timescale 1ns / 1ps

module three_queue_shortest_dispatch_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tqsd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [tqsd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [tqsd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [tqsd_pkg::CMD_W-1:0]      in_command,
  input  logic [tqsd_pkg::QSEL_W-1:0]     in_queue_select,
  input  logic [tqsd_pkg::COUNT_W-1:0]    in_product_count,
  input  logic [tqsd_pkg::CENTS_W-1:0]    in_purchase_cents,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [tqsd_pkg::STATUS_W-1:0]   out_status,
  output logic [tqsd_pkg::QSEL_W-1:0]     out_queue_used,
  output logic [tqsd_pkg::ID_W-1:0]       out_client_id,
  output logic [tqsd_pkg::TOTAL_W-1:0]    out_total_cents
);
  import tqsd_pkg::*;

  // product counts and ids are never read back by any command, so only
  // the cents values are kept in the store
  logic [LIMIT_W-1:0] queue_limit;
  ram_req_t           ram_req;
  logic [CENTS_W-1:0] ram_rd_data;

  tqsd_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .queue_limit (queue_limit)
  );

  tqsd_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rd_data)
  );

  tqsd_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .queue_limit       (queue_limit),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_queue_select   (in_queue_select),
    .in_purchase_cents (in_purchase_cents),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_queue_used    (out_queue_used),
    .out_client_id     (out_client_id),
    .out_total_cents   (out_total_cents),
    .ram_req           (ram_req),
    .ram_rd_data       (ram_rd_data)
  );

endmodule

/* src/tqsd_ram.sv */
// value store: one ring of slots per queue, one write and one read port
// depends on tqsd_pkg
`timescale 1ns / 1ps

module tqsd_ram (
  input  logic                      clk,
  input  tqsd_pkg::ram_req_t        req,
  output logic [tqsd_pkg::CENTS_W-1:0] rd_data
);
  import tqsd_pkg::*;

  logic [CENTS_W-1:0] mem [SLOT_COUNT];
  logic [CENTS_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* src/tqsd_cfg.sv */
// apb register file holding the queue limit
// depends on tqsd_pkg
`timescale 1ns / 1ps

module tqsd_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tqsd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [tqsd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [tqsd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output logic [tqsd_pkg::LIMIT_W-1:0]   queue_limit
);
  import tqsd_pkg::*;

  logic [LIMIT_W-1:0]   queue_limit_r;
  logic [CFG_IDX_W-1:0] reg_idx;
  logic                 wr_limit;

  assign reg_idx  = paddr[CFG_ADDR_W-1:2];
  assign pready   = 1'b1;
  assign wr_limit = psel & penable & pwrite & pready & (reg_idx == CFG_IDX_LIMIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      queue_limit_r <= LIMIT_RESET;
    end else if (wr_limit) begin
      queue_limit_r <= pwdata[LIMIT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == CFG_IDX_LIMIT) begin
      prdata = CFG_DATA_W'(queue_limit_r);
    end
  end

  assign queue_limit = queue_limit_r;

endmodule

/* src/tqsd_ctrl.sv */
// command sequencer: queue pointers, occupancies, id counter and the
// accumulator that walks a queue through the value store; depends on tqsd_pkg
`timescale 1ns / 1ps
`include "three_queue_shortest_dispatch_top_defines.svh"

module tqsd_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [tqsd_pkg::LIMIT_W-1:0]    queue_limit,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [tqsd_pkg::CMD_W-1:0]      in_command,
  input  logic [tqsd_pkg::QSEL_W-1:0]     in_queue_select,
  input  logic [tqsd_pkg::CENTS_W-1:0]    in_purchase_cents,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [tqsd_pkg::STATUS_W-1:0]   out_status,
  output logic [tqsd_pkg::QSEL_W-1:0]     out_queue_used,
  output logic [tqsd_pkg::ID_W-1:0]       out_client_id,
  output logic [tqsd_pkg::TOTAL_W-1:0]    out_total_cents,
  output tqsd_pkg::ram_req_t              ram_req,
  input  logic [tqsd_pkg::CENTS_W-1:0]    ram_rd_data
);
  import tqsd_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DECODE = 2'd1;
  localparam logic [1:0] ST_SUM    = 2'd2;
  localparam logic [1:0] ST_RESULT = 2'd3;

  function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] ptr,
                                                input logic [OCC_W-1:0] offs);
    logic [OCC_W:0] s;
    s = (OCC_W+1)'(ptr) + (OCC_W+1)'(offs);
    if (s >= (OCC_W+1)'(QUEUE_DEPTH)) begin
      s = s - (OCC_W+1)'(QUEUE_DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] ring_inc(input logic [PTR_W-1:0] ptr);
    return (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [QSEL_W-1:0] q,
                                                  input logic [PTR_W-1:0] ptr);
    logic [ADDR_W-1:0] base;
    case (q)
      2'd0:    base = '0;
      2'd1:    base = ADDR_W'(QUEUE_DEPTH);
      default: base = ADDR_W'(2 * QUEUE_DEPTH);
    endcase
    return base + ADDR_W'(ptr);
  endfunction

  logic [1:0]          state_r, state_nxt;
  logic [CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [QSEL_W-1:0]   sel_r, sel_nxt;
  logic [CENTS_W-1:0]  cents_r, cents_nxt;
  logic [OCC_W-1:0]    occ_r [QUEUE_COUNT];
  logic [OCC_W-1:0]    occ_nxt [QUEUE_COUNT];
  logic [PTR_W-1:0]    head_r [QUEUE_COUNT];
  logic [PTR_W-1:0]    head_nxt [QUEUE_COUNT];
  logic [ID_W-1:0]     next_id_r, next_id_nxt;

  logic [QSEL_W-1:0]   sum_q_r, sum_q_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [OCC_W-1:0]    left_r, left_nxt;
  logic                pend_r, pend_nxt;
  logic [TOTAL_W-1:0]  acc_r, acc_nxt;

  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [QSEL_W-1:0]   res_used_r, res_used_nxt;
  logic [ID_W-1:0]     res_id_r, res_id_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [QSEL_W-1:0]   out_used_r, out_used_nxt;
  logic [ID_W-1:0]     out_id_r, out_id_nxt;
  logic [TOTAL_W-1:0]  out_total_r, out_total_nxt;

  logic [QSEL_W-1:0]   auto_q, dec_q;
  logic [OCC_W-1:0]    occ_q;
  logic [CMP_W-1:0]    lim_ext, eff_limit;
  logic                sel_invalid, is_push, q_full;

  // queue choice and checks, all from the latched command
  always_comb begin
    if (occ_r[0] <= occ_r[1] && occ_r[0] <= occ_r[2]) begin
      auto_q = 2'd0;
    end else if (occ_r[1] <= occ_r[0] && occ_r[1] <= occ_r[2]) begin
      auto_q = 2'd1;
    end else begin
      auto_q = 2'd2;
    end
    sel_invalid = (cmd_r != CMD_AUTO) && (sel_r == Q_NONE);
    is_push     = (cmd_r == CMD_PUSH) || (cmd_r == CMD_AUTO);
    if (cmd_r == CMD_AUTO) begin
      dec_q = auto_q;
    end else if (sel_invalid) begin
      dec_q = '0;
    end else begin
      dec_q = sel_r - QSEL_W'(1);
    end
    occ_q     = occ_r[dec_q];
    lim_ext   = CMP_W'(queue_limit);
    eff_limit = (lim_ext > CMP_W'(QUEUE_DEPTH)) ? CMP_W'(QUEUE_DEPTH) : lim_ext;
    q_full    = CMP_W'(occ_q) >= eff_limit;
  end

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    sel_nxt        = sel_r;
    cents_nxt      = cents_r;
    occ_nxt        = occ_r;
    head_nxt       = head_r;
    next_id_nxt    = next_id_r;
    sum_q_nxt      = sum_q_r;
    rd_ptr_nxt     = rd_ptr_r;
    left_nxt       = left_r;
    pend_nxt       = pend_r;
    acc_nxt        = acc_r;
    res_status_nxt = res_status_r;
    res_used_nxt   = res_used_r;
    res_id_nxt     = res_id_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_used_nxt   = out_used_r;
    out_id_nxt     = out_id_r;
    out_total_nxt  = out_total_r;
    ram_req        = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_command;
          sel_nxt   = in_queue_select;
          cents_nxt = in_purchase_cents;
          state_nxt = ST_DECODE;
        end
      end

      ST_DECODE: begin
        res_id_nxt     = '0;
        acc_nxt        = '0;
        res_status_nxt = STS_OK;
        res_used_nxt   = dec_q + QSEL_W'(1);
        state_nxt      = ST_RESULT;
        if (sel_invalid) begin
          res_status_nxt = STS_INVALID;
          res_used_nxt   = Q_NONE;
        end else if (is_push) begin
          if (q_full) begin
            res_status_nxt = STS_FULL;
          end else begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = slot_addr(dec_q, ring_add(head_r[dec_q], occ_q));
            ram_req.wr_data = cents_r;
            occ_nxt[dec_q]  = occ_q + OCC_W'(1);
            res_id_nxt      = next_id_r;
            next_id_nxt     = next_id_r + ID_W'(1);
          end
        end else if (cmd_r == CMD_POP) begin
          if (occ_q == '0) begin
            res_status_nxt = STS_EMPTY;
          end else begin
            head_nxt[dec_q] = ring_inc(head_r[dec_q]);
            occ_nxt[dec_q]  = occ_q - OCC_W'(1);
          end
        end else begin
          sum_q_nxt  = dec_q;
          rd_ptr_nxt = head_r[dec_q];
          left_nxt   = occ_q;
          pend_nxt   = 1'b0;
          state_nxt  = ST_SUM;
        end
      end

      // one read issued and one value added per cycle, read data arriving in the cycle after its read
      ST_SUM: begin
        pend_nxt = 1'b0;
        if (left_r != '0) begin
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = slot_addr(sum_q_r, rd_ptr_r);
          rd_ptr_nxt      = ring_inc(rd_ptr_r);
          left_nxt        = left_r - OCC_W'(1);
          pend_nxt        = 1'b1;
        end
        if (pend_r) begin
          acc_nxt = acc_r + TOTAL_W'(ram_rd_data);
        end
        if (left_r == '0 && !pend_r) begin
          state_nxt = ST_RESULT;
        end
      end

      ST_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_used_nxt   = res_used_r;
          out_id_nxt     = res_id_r;
          out_total_nxt  = acc_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      occ_r       <= '{default: '0};
      head_r      <= '{default: '0};
      next_id_r   <= '0;
      pend_r      <= 1'b0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      head_r      <= head_nxt;
      next_id_r   <= next_id_nxt;
      pend_r      <= pend_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    sel_r        <= sel_nxt;
    cents_r      <= cents_nxt;
    sum_q_r      <= sum_q_nxt;
    rd_ptr_r     <= rd_ptr_nxt;
    acc_r        <= acc_nxt;
    res_status_r <= res_status_nxt;
    res_used_r   <= res_used_nxt;
    res_id_r     <= res_id_nxt;
    out_status_r <= out_status_nxt;
    out_used_r   <= out_used_nxt;
    out_id_r     <= out_id_nxt;
    out_total_r  <= out_total_nxt;
  end

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_queue_used  = out_used_r;
  assign out_client_id   = out_id_r;
  assign out_total_cents = out_total_r;

  `TQSD_CHECK(a_occ_bound, (occ_r[0] <= OCC_W'(QUEUE_DEPTH)) && (occ_r[1] <= OCC_W'(QUEUE_DEPTH)) && (occ_r[2] <= OCC_W'(QUEUE_DEPTH)), "queue occupancy above depth")
  `TQSD_CHECK(a_id_step, ram_req.wr_en |=> next_id_r == $past(next_id_r) + ID_W'(1), "id counter did not advance on a stored push")
  `TQSD_CHECK(a_one_port_op, !(ram_req.wr_en && ram_req.rd_en), "store written and read in one cycle")
  `TQSD_CHECK(a_total_ok, (out_valid_r && (out_total_r != '0)) |-> out_status_r == STS_OK, "nonzero total with a failing status")
  `TQSD_CHECK_ALWAYS(a_reset_idle, !rst_n |=> (state_r == ST_IDLE) && !out_valid_r, "not idle after reset")

endmodule

/* tb/tb_three_queue_shortest_dispatch_top.sv */
// testbench for the three-queue shortest dispatch block: directed table, then random phases
// predicts every result from a local copy of the queues; depends on tqsd_pkg and the top level
`timescale 1ns / 1ps

module tb_three_queue_shortest_dispatch_top;
  import tqsd_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_COUNT  = 8;
  localparam int PHASE_ITEMS  = 50;
  localparam int EXPECT_DEPTH = 64;
  localparam int ROW_DEPTH    = 64;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [QSEL_W-1:0]   queue_used;
    logic [ID_W-1:0]     client_id;
    logic [TOTAL_W-1:0]  total_cents;
  } dispatch_result_t;

  typedef enum logic {ROW_ITEM, ROW_LIMIT} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [CMD_W-1:0]   cmd;
    logic [QSEL_W-1:0]  sel;
    logic [COUNT_W-1:0] count;
    logic [CENTS_W-1:0] cents;
    logic [LIMIT_W-1:0] limit;
    logic               typed;
    dispatch_result_t   res;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [CMD_W-1:0]      in_command = '0;
  logic [QSEL_W-1:0]     in_queue_select = '0;
  logic [COUNT_W-1:0]    in_product_count = '0;
  logic [CENTS_W-1:0]    in_purchase_cents = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [STATUS_W-1:0]   out_status;
  logic [QSEL_W-1:0]     out_queue_used;
  logic [ID_W-1:0]       out_client_id;
  logic [TOTAL_W-1:0]    out_total_cents;

  three_queue_shortest_dispatch_top i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_queue_select   (in_queue_select),
    .in_product_count  (in_product_count),
    .in_purchase_cents (in_purchase_cents),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_queue_used    (out_queue_used),
    .out_client_id     (out_client_id),
    .out_total_cents   (out_total_cents)
  );

  // shadow of the queues
  logic [CENTS_W-1:0] rec_value [QUEUE_COUNT][QUEUE_DEPTH];
  int                 queue_head [QUEUE_COUNT] = '{0, 0, 0};
  int                 queue_occ  [QUEUE_COUNT] = '{0, 0, 0};
  logic [ID_W-1:0]    next_client_id = '0;
  logic [LIMIT_W-1:0] model_limit = LIMIT_RESET;

  // expected results in acceptance order, ring indexed by running counts
  dispatch_result_t expect_ring [EXPECT_DEPTH];
  int               expect_wr = 0;
  int               expect_rd = 0;
  stim_row_t        directed_rows [ROW_DEPTH];
  int               row_count = 0;
  dispatch_result_t oldest_result;

  int  fail_count = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  limit_writes = 0;
  int  status_tally [4] = '{0, 0, 0, 0};
  int  cycle_count = 0;
  bit  idle_on = 1'b1;
  bit  valid_dropped = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expect_wr - expect_rd);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at cycle %0d, %s: got %0h expected %0h", cycle_count, what, got, want);
    fail_count++;
  endtask

  function automatic dispatch_result_t dispatch_predict(input logic [CMD_W-1:0] cmd,
                                                        input logic [QSEL_W-1:0] sel,
                                                        input logic [CENTS_W-1:0] cents);
    dispatch_result_t r;
    int q;
    int cap;
    logic [TOTAL_W-1:0] sum;
    r = '0;
    q = -1;
    sum = '0;
    cap = (model_limit > QUEUE_DEPTH) ? QUEUE_DEPTH : int'(model_limit);
    if (cmd == CMD_AUTO) begin
      // shortest queue, ties go to the lower number; no fallback when it is full
      if (queue_occ[0] <= queue_occ[1] && queue_occ[0] <= queue_occ[2]) q = 0;
      else if (queue_occ[1] <= queue_occ[0] && queue_occ[1] <= queue_occ[2]) q = 1;
      else q = 2;
    end else if (sel == Q_NONE) begin
      r.status = STS_INVALID;
    end else begin
      q = int'(sel) - 1;
    end
    if (q >= 0) begin
      r.queue_used = QSEL_W'(q + 1);
      if (cmd == CMD_AUTO || cmd == CMD_PUSH) begin
        if (queue_occ[q] >= cap) begin
          r.status = STS_FULL;
        end else begin
          rec_value[q][(queue_head[q] + queue_occ[q]) % QUEUE_DEPTH] = cents;
          queue_occ[q]++;
          r.client_id = next_client_id;
          next_client_id = next_client_id + ID_W'(1);
        end
      end else if (cmd == CMD_POP) begin
        if (queue_occ[q] == 0) begin
          r.status = STS_EMPTY;
        end else begin
          queue_head[q] = (queue_head[q] + 1) % QUEUE_DEPTH;
          queue_occ[q]--;
        end
      end else begin
        for (int i = 0; i < queue_occ[q]; i++)
          sum = sum + TOTAL_W'(rec_value[q][(queue_head[q] + i) % QUEUE_DEPTH]);
        r.total_cents = sum;
      end
    end
    return r;
  endfunction

  // leaves in_valid high at the acceptance edge so a following item can go back to back
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [QSEL_W-1:0] sel,
                           input logic [COUNT_W-1:0] count, input logic [CENTS_W-1:0] cents,
                           input logic typed, input dispatch_result_t typed_res);
    dispatch_result_t r;
    if (valid_dropped || (idle_on && $urandom_range(0, 99) < 10)) begin
      if (!valid_dropped) in_valid <= 1'b0;
      @(posedge clk);
      while (idle_on && $urandom_range(0, 99) < 10) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_queue_select <= sel;
    in_product_count <= count;
    in_purchase_cents <= cents;
    valid_dropped = 1'b0;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    r = dispatch_predict(cmd, sel, cents);
    if (typed) r = typed_res;
    expect_ring[expect_wr % EXPECT_DEPTH] = r;
    expect_wr++;
    status_tally[r.status]++;
    items_sent++;
  endtask

  task automatic drop_valid();
    if (!valid_dropped) begin
      in_valid <= 1'b0;
      valid_dropped = 1'b1;
    end
  endtask

  task automatic wait_drained();
    while (expect_wr != expect_rd) @(posedge clk);
  endtask

  // write the limit register once the block is idle, then read it back
  task automatic set_queue_limit(input logic [CFG_DATA_W-1:0] data);
    drop_valid();
    wait_drained();
    repeat (4) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {CFG_IDX_LIMIT, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    model_limit = data[LIMIT_W-1:0];
    limit_writes++;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    if (prdata !== {{(CFG_DATA_W-LIMIT_W){1'b0}}, model_limit})
      report_mismatch("limit read back", 64'(prdata), 64'(model_limit));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic add_row(input stim_row_t row);
    directed_rows[row_count] = row;
    row_count++;
  endtask

  task automatic item_row(input logic [CMD_W-1:0] cmd, input logic [QSEL_W-1:0] sel,
                          input logic [COUNT_W-1:0] count, input logic [CENTS_W-1:0] cents);
    stim_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.cmd = cmd;
    row.sel = sel;
    row.count = count;
    row.cents = cents;
    add_row(row);
  endtask

  task automatic item_row_exp(input logic [CMD_W-1:0] cmd, input logic [QSEL_W-1:0] sel,
                              input logic [COUNT_W-1:0] count,
                              input logic [CENTS_W-1:0] cents,
                              input logic [STATUS_W-1:0] status,
                              input logic [QSEL_W-1:0] used, input logic [ID_W-1:0] id,
                              input logic [TOTAL_W-1:0] total);
    stim_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.cmd = cmd;
    row.sel = sel;
    row.count = count;
    row.cents = cents;
    row.typed = 1'b1;
    row.res = '{status: status, queue_used: used, client_id: id, total_cents: total};
    add_row(row);
  endtask

  task automatic limit_row(input logic [LIMIT_W-1:0] limit);
    stim_row_t row;
    row = '0;
    row.kind = ROW_LIMIT;
    row.limit = limit;
    add_row(row);
  endtask

  // result checker and receiver stall
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      results_seen++;
      if (expect_wr == expect_rd) begin
        report_mismatch("result with nothing expected, status", 64'(out_status), 64'(0));
      end else begin
        oldest_result = expect_ring[expect_rd % EXPECT_DEPTH];
        expect_rd++;
        if (out_status !== oldest_result.status)
          report_mismatch("status", 64'(out_status), 64'(oldest_result.status));
        if (out_queue_used !== oldest_result.queue_used)
          report_mismatch("queue_used", 64'(out_queue_used), 64'(oldest_result.queue_used));
        if (out_client_id !== oldest_result.client_id)
          report_mismatch("client_id", 64'(out_client_id), 64'(oldest_result.client_id));
        if (out_total_cents !== oldest_result.total_cents)
          report_mismatch("total_cents", 64'(out_total_cents),
                          64'(oldest_result.total_cents));
      end
    end
    out_stall <= idle_on && ($urandom_range(0, 99) < 10);
  end

  initial begin : stimulus
    stim_row_t row;
    dispatch_result_t no_res;
    logic [CMD_W-1:0] cmd;
    logic [QSEL_W-1:0] sel;
    logic [COUNT_W-1:0] count;
    logic [CENTS_W-1:0] cents;
    logic [CFG_DATA_W-1:0] wdata;
    int mode;
    int fav;
    int pick;

    no_res = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // empty queues, invalid numbers and payload extremes straight after reset
    item_row_exp(CMD_TOTAL, 2'd1, 16'd0, 32'd0, STS_OK, 2'd1, 32'd0, 36'd0);
    item_row_exp(CMD_POP, 2'd2, 16'd0, 32'd0, STS_EMPTY, 2'd2, 32'd0, 36'd0);
    item_row_exp(CMD_PUSH, Q_NONE, 16'hffff, 32'hffffffff, STS_INVALID, Q_NONE, 32'd0, 36'd0);
    item_row_exp(CMD_POP, Q_NONE, 16'd0, 32'd0, STS_INVALID, Q_NONE, 32'd0, 36'd0);
    item_row_exp(CMD_TOTAL, Q_NONE, 16'd0, 32'd0, STS_INVALID, Q_NONE, 32'd0, 36'd0);
    item_row_exp(CMD_PUSH, 2'd1, 16'hffff, 32'hffffffff, STS_OK, 2'd1, 32'd0, 36'd0);
    item_row_exp(CMD_PUSH, 2'd1, 16'd0, 32'd0, STS_OK, 2'd1, 32'd1, 36'd0);
    item_row_exp(CMD_TOTAL, 2'd1, 16'd0, 32'd0, STS_OK, 2'd1, 32'd0, 36'h0ffffffff);
    // automatic choice with the select field ignored
    item_row(CMD_AUTO, Q_NONE, 16'd1234, 32'd100);
    item_row(CMD_AUTO, 2'd3, 16'd7, 32'd250);
    item_row(CMD_AUTO, 2'd2, 16'd9, 32'd999);
    item_row(CMD_POP, 2'd1, 16'd0, 32'd0);
    item_row(CMD_TOTAL, 2'd1, 16'd0, 32'd0);
    // a limit of zero refuses every push
    limit_row(5'd0);
    item_row_exp(CMD_PUSH, 2'd3, 16'd1, 32'd5, STS_FULL, 2'd3, 32'd0, 36'd0);
    item_row(CMD_AUTO, 2'd1, 16'd1, 32'd5);
    // limit lowered below what queue 2 holds
    limit_row(5'd1);
    item_row(CMD_PUSH, 2'd2, 16'd3, 32'd33);
    item_row(CMD_POP, 2'd2, 16'd0, 32'd0);
    item_row(CMD_PUSH, 2'd2, 16'd3, 32'd33);
    item_row(CMD_POP, 2'd2, 16'd0, 32'd0);
    item_row(CMD_PUSH, 2'd2, 16'd3, 32'd33);
    // largest limit value, capped at the queue depth
    limit_row(5'd31);
    item_row(CMD_PUSH, 2'd3, 16'hffff, 32'hffffffff);
    item_row(CMD_PUSH, 2'd3, 16'h8000, 32'hffffffff);
    item_row(CMD_PUSH, 2'd3, 16'h0001, 32'hffffffff);
    item_row(CMD_TOTAL, 2'd3, 16'd0, 32'd0);

    for (int i = 0; i < row_count; i++) begin
      row = directed_rows[i];
      if (row.kind == ROW_LIMIT)
        set_queue_limit({{(CFG_DATA_W-LIMIT_W){1'b0}}, row.limit});
      else
        send_item(row.cmd, row.sel, row.count, row.cents, row.typed, row.res);
    end

    // random phases: each starts from an idle block with a fresh limit
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        0: wdata = 32'd16;
        1: wdata = 32'd31;
        2: wdata = 32'd0;
        3: wdata = 32'd1;
        default: wdata = ($urandom & ~32'h1f) | $urandom_range(0, 31);
      endcase
      set_queue_limit(wdata);
      // one stretch with both sides always ready
      idle_on = (ph != 4);
      case (ph)
        0, 1, 4: mode = 0;
        2, 5:    mode = 1;
        default: mode = 2;
      endcase
      fav = $urandom_range(1, 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (mode == 0)
          cmd = (pick < 45) ? CMD_PUSH : (pick < 75) ? CMD_AUTO :
                (pick < 85) ? CMD_TOTAL : CMD_POP;
        else if (mode == 1)
          cmd = (pick < 50) ? CMD_POP : (pick < 70) ? CMD_TOTAL :
                (pick < 85) ? CMD_PUSH : CMD_AUTO;
        else
          cmd = pick[1:0];
        pick = $urandom_range(0, 99);
        if (pick < 8) sel = Q_NONE;
        else if (mode != 2 && pick < 60) sel = QSEL_W'(fav);
        else sel = QSEL_W'($urandom_range(1, 3));
        pick = $urandom_range(0, 99);
        cents = (pick < 20) ? 32'hffffffff : (pick < 25) ? 32'd0 : $urandom;
        pick = $urandom_range(0, 99);
        count = (pick < 10) ? 16'hffff : (pick < 15) ? 16'd0 :
                COUNT_W'($urandom_range(0, 65535));
        send_item(cmd, sel, count, cents, 1'b0, no_res);
      end
    end

    idle_on = 1'b1;
    drop_valid();
    wait_drained();
    repeat (30) @(posedge clk);
    $display("sent %0d items: %0d ok, %0d full, %0d empty, %0d invalid queue number",
             items_sent, status_tally[STS_OK], status_tally[STS_FULL],
             status_tally[STS_EMPTY], status_tally[STS_INVALID]);
    $display("checked %0d results across %0d queue limit settings, %0d mismatches",
             results_seen, limit_writes, fail_count);
    if (fail_count == 0 && expect_wr == expect_rd) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
